// ----- rtl/core/flow_key_hash_table_core_macros.svh -----
// ----------------------------------------------------------------------------
// flow key hash table assertion macros
// concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef FLOW_KEY_HASH_TABLE_CORE_MACROS_SVH
`define FLOW_KEY_HASH_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define FKHT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fkht assertion failed");
// checked at every edge, reset included
`define FKHT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fkht assertion failed");
`else
`define FKHT_ASSERT(lbl, clk, rst, prop)
`define FKHT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/core/fkht_pkg.sv -----
// ----------------------------------------------------------------------------
// fkht_pkg
// shared types and constants of the flow key hash table
// ----------------------------------------------------------------------------
package fkht_pkg;

  // bucket geometry; BINS must be a power of two (bin is the low hash bits)
  localparam int BINS  = 1024;
  localparam int WAYS  = 4;
  localparam int BIN_W = $clog2(BINS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int IPS_W   = 64;
  localparam int PORTS_W = 32;
  localparam int VAL_W   = 31;

  typedef enum logic [1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [IPS_W-1:0]   ips;
    logic [PORTS_W-1:0] ports;
    logic [VAL_W-1:0]   value;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [IPS_W-1:0]   ips;
    logic [PORTS_W-1:0] ports;
    logic [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic             wr;
    status_t          status;
    logic [VAL_W-1:0] value;
  } upd_t;

endpackage

// ----- rtl/core/fkht_ram.sv -----
// ----------------------------------------------------------------------------
// fkht_ram
// single-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module fkht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/core/fkht_bucket.sv -----
// ----------------------------------------------------------------------------
// fkht_bucket
// key match, free-way search and row update for one bucket
// ----------------------------------------------------------------------------
module fkht_bucket (
  input  fkht_pkg::row_t row,
  input  fkht_pkg::req_t req,
  output fkht_pkg::row_t row_next,
  output fkht_pkg::upd_t upd
);

  logic                     hit_found;
  logic [fkht_pkg::WAY_W-1:0] hit_way;
  logic                     free_found;
  logic [fkht_pkg::WAY_W-1:0] free_way;

  // lowest matching valid way, lowest invalid way
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < fkht_pkg::WAYS; w++) begin
      if (row[w].valid) begin
        if (!hit_found && row[w].ips == req.ips && row[w].ports == req.ports) begin
          hit_found = 1'b1;
          hit_way   = fkht_pkg::WAY_W'(w);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_way   = fkht_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    row_next   = row;
    upd.wr     = 1'b0;
    upd.status = fkht_pkg::STAT_OK;
    upd.value  = '0;
    case (fkht_pkg::op_t'(req.op))
      fkht_pkg::OP_GET: begin
        if (hit_found) begin
          upd.value = row[hit_way].value;
        end else begin
          upd.status = fkht_pkg::STAT_ABSENT;
        end
      end
      fkht_pkg::OP_SET: begin
        if (hit_found) begin
          upd.wr                  = 1'b1;
          row_next[hit_way].value = req.value;
        end else if (free_found) begin
          upd.wr                   = 1'b1;
          row_next[free_way].valid = 1'b1;
          row_next[free_way].ips   = req.ips;
          row_next[free_way].ports = req.ports;
          row_next[free_way].value = req.value;
        end else begin
          upd.status = fkht_pkg::STAT_FULL;
        end
      end
      fkht_pkg::OP_DEL: begin
        if (hit_found) begin
          upd.wr                  = 1'b1;
          row_next[hit_way].valid = 1'b0;
        end else begin
          upd.status = fkht_pkg::STAT_ABSENT;
        end
      end
      default: begin
        // unused op code: no change, ok status
      end
    endcase
  end

endmodule

// ----- rtl/core/flow_key_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// flow_key_hash_table_core
// exact-match flow table, one bucket of ways per bin, in a single ram
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one item: op (get, set, delete),
//   the flow key src_ip, dst_ip, sport, dport and new_value for set
//   output channel (out_valid/out_ready) returns one item per input item:
//   status (ok, key absent, bucket full) and found_value on a get hit
//   an item is accepted in the idle state; its bucket row is read at the
//   accept edge, compared and written back when the lookup stage fires,
//   which also loads the output register with the result
//   the single ram port does the row read and then the row write back of the
//   same item, and the next item is accepted only once it leaves the lookup stage
//   the output register lets the next item be accepted while a result waits;
//   a stalled receiver holds that next item in the lookup stage until the
//   output register frees up, and no further item is accepted meanwhile
//   after reset a clearing pass writes empty rows to all BINS rows, one row
//   per cycle; in_ready stays low until it ends
// ----------------------------------------------------------------------------
`include "flow_key_hash_table_core_macros.svh"

module flow_key_hash_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] sport,
  input  logic [15:0] dport,
  input  logic [30:0] new_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [30:0] found_value
);

  fkht_pkg::state_t state, state_next;

  // clear pass row pointer
  logic [fkht_pkg::BIN_W-1:0] clr_addr;

  // request held for the lookup stage
  fkht_pkg::req_t             req;
  logic [fkht_pkg::BIN_W-1:0] req_bin;

  fkht_pkg::req_t             in_req;
  logic [63:0]                hash;
  logic [fkht_pkg::BIN_W-1:0] in_bin;

  logic accept;
  logic fire;
  logic clearing;

  logic                       ram_en;
  logic                       ram_we;
  logic [fkht_pkg::BIN_W-1:0] ram_addr;
  fkht_pkg::row_t             ram_wdata;
  fkht_pkg::row_t             ram_rdata;

  fkht_pkg::row_t row_next;
  fkht_pkg::upd_t upd;

  fkht_pkg::status_t status_reg;

  // key packing and bin: low bits of ips ^ sport ^ dport
  assign in_req.op    = op;
  assign in_req.ips   = {src_ip, dst_ip};
  assign in_req.ports = {sport, dport};
  assign in_req.value = new_value;
  assign hash         = {src_ip, dst_ip} ^ {48'd0, sport} ^ {48'd0, dport};
  assign in_bin       = hash[fkht_pkg::BIN_W-1:0];

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fkht_pkg::S_CLEAR: begin
        if (clr_addr == fkht_pkg::BIN_W'(fkht_pkg::BINS - 1)) begin
          state_next = fkht_pkg::S_IDLE;
        end
      end
      fkht_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = fkht_pkg::S_LOOKUP;
        end
      end
      fkht_pkg::S_LOOKUP: begin
        if (!out_valid || out_ready) begin
          state_next = fkht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fkht_pkg::S_CLEAR;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    clearing = 1'b0;
    fire     = 1'b0;
    case (state)
      fkht_pkg::S_CLEAR:  clearing = 1'b1;
      fkht_pkg::S_IDLE:   in_ready = 1'b1;
      fkht_pkg::S_LOOKUP: fire     = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fkht_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= in_req;
      req_bin <= in_bin;
    end
  end

  // ram port: clear writes, read at accept, write back at lookup
  assign ram_we    = clearing || (fire && upd.wr);
  assign ram_en    = ram_we || accept;
  assign ram_wdata = clearing ? fkht_pkg::row_t'('0) : row_next;

  always_comb begin
    case (state)
      fkht_pkg::S_CLEAR:  ram_addr = clr_addr;
      fkht_pkg::S_LOOKUP: ram_addr = req_bin;
      default:            ram_addr = in_bin;
    endcase
  end

  fkht_ram #(
    .WIDTH ($bits(fkht_pkg::row_t)),
    .DEPTH (fkht_pkg::BINS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  fkht_bucket u_bucket (
    .row      (ram_rdata),
    .req      (req),
    .row_next (row_next),
    .upd      (upd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_reg  <= upd.status;
      found_value <= upd.value;
    end
  end

  assign status = status_reg;

  // an accepted item is in the lookup stage at the next edge
  `FKHT_ASSERT(a_accept_to_lookup, clk, rst, accept |=> state == fkht_pkg::S_LOOKUP)
  // no item is taken while the clearing pass runs
  `FKHT_ASSERT(a_no_accept_clear, clk, rst, state == fkht_pkg::S_CLEAR |-> !in_ready)
  // ram writes only from the clearing pass or the lookup write back
  `FKHT_ASSERT(a_we_source, clk, rst,
    ram_we |-> (state == fkht_pkg::S_CLEAR || state == fkht_pkg::S_LOOKUP))
  // a new result only comes out of the lookup stage
  `FKHT_ASSERT(a_result_from_lookup, clk, rst,
    $rose(out_valid) |-> $past(state) == fkht_pkg::S_LOOKUP)

endmodule
